// ----- rtl/blt_pkg.sv -----
// Package for the bucket lock table: sizes, word types, operation codes
// and small helper functions. No dependencies.
`default_nettype none

package blt_pkg;

    // Table geometry
    localparam int TABLE_COUNT      = 4;
    localparam int NUM_BUCKETS      = 256;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int KEY_WIDTH        = 32;

    localparam int ROWS    = TABLE_COUNT * NUM_BUCKETS;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

    localparam logic [7:0] SHARE_LIMIT = 8'd255;

    // Queue sizing shared by the job queue and the result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ROW_W-1:0]     row_idx_t;
    typedef logic [SLOT_W-1:0]    slot_idx_t;

    // Input word
    typedef struct packed {
        logic        command;
        logic [1:0]  table_index;
        logic [7:0]  bucket_index;
        logic [1:0]  slot_select;
        logic [31:0] lookup_key;
        logic        entry_valid;
        logic        release_req;
        logic        exclusive_mode;
    } req_t;

    // Result word
    typedef struct packed {
        logic       hit;
        logic [1:0] slot_found;
        logic       granted;
        logic [7:0] count_seen;
    } res_t;

    // Command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_SH_LOCK   = 3'd2,
        OP_EX_LOCK   = 3'd3,
        OP_SH_UNLOCK = 3'd4,
        OP_EX_UNLOCK = 3'd5
    } op_t;

    // Classified job handed from front to back
    typedef struct packed {
        op_t       op;
        row_idx_t  row;
        slot_idx_t slot;
        key_t      key;
        logic      valid;
    } job_t;

    // One slot of a bucket row
    typedef struct packed {
        key_t       key;
        logic       valid;
        logic       excl;
        logic [7:0] count;
    } slot_t;

    typedef slot_t [SLOTS_PER_BUCKET-1:0] row_t;

    // Low KEY_WIDTH bits of the 32-bit input key, zero extended if wider
    function automatic key_t key_of(input logic [31:0] k);
        key_t r;
        r = '0;
        for (int i = 0; i < KEY_WIDTH; i++)
        begin
            r[i] = (i < 32) ? k[i] : 1'b0;
        end
        return r;
    endfunction

    function automatic row_idx_t row_of(input logic [1:0] t, input logic [7:0] b);
        return ROW_W'(int'(t) * NUM_BUCKETS + int'(b));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bucket_lock_table_unit.sv -----
// Top level of the shared/exclusive bucket lock table.
// Depends on blt_pkg, blt_front, blt_back and blt_resq.
// Usage:
//  - Request side is a queue write port: a request word is taken on a rising
//    edge with push high and full low. command selects a slot load or a
//    lock/unlock request; table_index and bucket_index pick the bucket row.
//  - Result side is a queue read port: while empty is low the oldest result
//    word sits on result; it is consumed on an edge with pop high.
//  - Every request word yields exactly one result word, in order. Loads and
//    out-of-range words return all zeros.
//  - A result word passes through the job queue, the registered row read
//    and the result queue before it shows on result. The back end takes a
//    new job only after the last one is done: it reads the bucket row, then compares and writes it back.
//  - Reset: after rst_n rises, a clearing pass walks all TABLE_COUNT *
//    NUM_BUCKETS rows zeroing valid bits and counters; full stays high for
//    that time.
//  - A 2-word job queue sits between the classifier and the execution
//    unit, and a 2-word result queue at the output. If the consumer stalls,
//    the result queue fills, the back end stops issuing, and then the job
//    queue fills and full rises. Nothing is dropped.
`default_nettype none

module bucket_lock_table_unit
    import blt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  req_t      request,
    output logic      empty,
    input  wire logic pop,
    output res_t      result
);

    logic clearing;
    logic job_empty;
    logic job_pop;
    job_t job;
    logic res_room;
    logic res_push;
    res_t res_data;

    // Classify and buffer incoming words
    blt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .hold      (clearing),
        .deq       (job_pop),
        .job_empty (job_empty),
        .job       (job)
    );

    // Row memory and lock rule execution
    blt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job),
        .job_pop   (job_pop),
        .res_room  (res_room),
        .res_push  (res_push),
        .res_data  (res_data),
        .clearing  (clearing)
    );

    // Output buffering toward the consumer
    blt_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (res_push),
        .enq_data (res_data),
        .room     (res_room),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

// ----- rtl/blt_front.sv -----
// Front end: input queue that classifies each request word into a job.
// Depends on blt_pkg.
`default_nettype none

module blt_front
    import blt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  req_t      request,
    input  wire logic hold,      // back end busy clearing
    input  wire logic deq,
    output logic      job_empty,
    output job_t      job
);

    job_t                q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                enq;
    logic                in_range;
    job_t                cls;

    // Classification
    always_comb
    begin
        in_range  = (int'(request.table_index) < TABLE_COUNT)
                 && (int'(request.bucket_index) < NUM_BUCKETS);
        cls       = '0;
        cls.row   = row_of(request.table_index, request.bucket_index);
        cls.slot  = SLOT_W'(request.slot_select);
        cls.key   = key_of(request.lookup_key);
        cls.valid = request.entry_valid;
        if (!in_range)
        begin
            cls.op = OP_NONE;
        end
        else if (request.command == CMD_LOAD)
        begin
            cls.op = (int'(request.slot_select) < SLOTS_PER_BUCKET) ? OP_LOAD : OP_NONE;
        end
        else
        begin
            case ({request.release_req, request.exclusive_mode})
                2'b00:   cls.op = OP_SH_LOCK;
                2'b01:   cls.op = OP_EX_LOCK;
                2'b10:   cls.op = OP_SH_UNLOCK;
                default: cls.op = OP_EX_UNLOCK;
            endcase
        end
    end

    assign full      = hold || (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign enq       = push && !full;
    assign job_empty = (cnt_reg == '0);
    assign job       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({enq, deq})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/blt_back.sv -----
// Back end: bucket row memory, post-reset clearing pass and the
// lock/unlock execution step. Depends on blt_pkg.
`default_nettype none

module blt_back
    import blt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_empty,
    input  job_t      job,
    output logic      job_pop,
    input  wire logic res_room,
    output logic      res_push,
    output res_t      res_data,
    output logic      clearing
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    row_idx_t                    clr_cnt_reg, clr_cnt_next;
    job_t                        cur_reg;
    row_t                        rd_row_reg;
    row_t                        row_mem [ROWS];

    logic                        mem_we;
    logic [SLOTS_PER_BUCKET-1:0] slot_we;
    row_idx_t                    mem_waddr;
    row_t                        wr_row;

    logic                        found;
    slot_idx_t                   idx;
    slot_t                       sel;
    slot_t                       upd;
    logic                        upd_we;
    res_t                        res;

    // Priority match over the bucket's slots, then the lock rule
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (!found && rd_row_reg[s].valid && (rd_row_reg[s].key == cur_reg.key))
            begin
                found = 1'b1;
                idx   = SLOT_W'(s);
            end
        end
        sel    = rd_row_reg[idx];
        upd    = sel;
        upd_we = 1'b0;
        res    = '0;
        case (cur_reg.op)
            OP_SH_LOCK:
            begin
                if (found)
                begin
                    res.count_seen = sel.count;
                    if (!sel.excl && (sel.count != SHARE_LIMIT))
                    begin
                        res.granted = 1'b1;
                        upd.count   = sel.count + 8'd1;
                        upd_we      = 1'b1;
                    end
                end
            end
            OP_EX_LOCK:
            begin
                if (found)
                begin
                    res.count_seen = sel.count;
                    if (!sel.excl && (sel.count == 8'd0))
                    begin
                        res.granted = 1'b1;
                        upd.excl    = 1'b1;
                        upd_we      = 1'b1;
                    end
                end
            end
            OP_SH_UNLOCK:
            begin
                if (found && (sel.count != 8'd0))
                begin
                    res.count_seen = sel.count;
                    res.granted    = 1'b1;
                    upd.count      = sel.count - 8'd1;
                    upd_we         = 1'b1;
                end
            end
            OP_EX_UNLOCK:
            begin
                if (found)
                begin
                    res.granted = 1'b1;
                    upd.excl    = 1'b0;
                    upd_we      = 1'b1;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        if ((cur_reg.op != OP_LOAD) && (cur_reg.op != OP_NONE))
        begin
            res.hit        = found;
            res.slot_found = 2'(idx);
        end
    end

    // Write port: clearing pass, load, or write-back of the updated slot
    always_comb
    begin
        mem_we    = 1'b0;
        slot_we   = '0;
        mem_waddr = cur_reg.row;
        wr_row    = rd_row_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            slot_we   = '1;
            mem_waddr = clr_cnt_reg;
            wr_row    = '0;
        end
        else if (state_reg == S_EXEC)
        begin
            if (cur_reg.op == OP_LOAD)
            begin
                mem_we                     = 1'b1;
                slot_we[cur_reg.slot]      = 1'b1;
                wr_row[cur_reg.slot].key   = cur_reg.key;
                wr_row[cur_reg.slot].valid = cur_reg.valid;
                wr_row[cur_reg.slot].excl  = 1'b0;
                wr_row[cur_reg.slot].count = 8'd0;
            end
            else if (upd_we)
            begin
                mem_we       = 1'b1;
                slot_we[idx] = 1'b1;
                wr_row[idx]  = upd;
            end
        end
    end

    assign job_pop  = (state_reg == S_IDLE) && !job_empty && res_room;
    assign res_push = (state_reg == S_EXEC);
    assign res_data = res;
    assign clearing = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_pop)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Row memory: one write port (per-slot enables), one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            begin
                if (slot_we[s])
                begin
                    row_mem[mem_waddr][s] <= wr_row[s];
                end
            end
        end
        if (job_pop)
        begin
            rd_row_reg <= row_mem[job.row];
            cur_reg    <= job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/blt_resq.sv -----
// Result queue: holds finished result words until the consumer pops them.
// Depends on blt_pkg.
`default_nettype none

module blt_resq
    import blt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic enq,
    input  res_t      enq_data,
    output logic      room,
    output logic      empty,
    input  wire logic pop,
    output res_t      result
);

    res_t                q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                deq;

    assign empty  = (cnt_reg == '0);
    assign room   = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign deq    = pop && !empty;
    assign result = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({enq, deq})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= enq_data;
        end
    end

endmodule

`default_nettype wire
